// File: rtl/core/fbwf_pkg.sv
// Shared types and codes for the fit-strategy block allocator.
`timescale 1ns / 1ps

package fbwf_pkg;

	// Placement rule codes as held in the strategy register
	typedef logic [1:0] strat_t;
	localparam strat_t STRAT_FIRST = 2'd0;
	localparam strat_t STRAT_BEST  = 2'd1;
	localparam strat_t STRAT_WORST = 2'd2;

	// Input beat action codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_REQUEST = 1'b1;

	// Register select, taken from paddr[2]
	localparam logic REG_STRATEGY    = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// Largest value the total free output can show
	localparam int TOTAL_W   = 20;
	localparam int TOTAL_MAX = 1048575;

	// Control bits of the search token that walks the cell chain
	typedef struct packed {
		logic valid;
		logic found;
	} tok_flags_t;

endpackage

// File: rtl/core/fbwf_cell.sv
// One block cell: holds a block's free size and updates the passing search token.
`timescale 1ns / 1ps

module fbwf_cell #(
	parameter int SIZE_WIDTH = 16,
	parameter int IDX_W      = 4,
	parameter int CNT_W      = 5,
	parameter int SUM_W      = 21,
	parameter int CELL_IDX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fbwf_pkg::strat_t    strategy,
	input  logic [CNT_W-1:0]    count,
	input  logic [SIZE_WIDTH-1:0] req_size,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic [SIZE_WIDTH-1:0] wr_data,
	input  fbwf_pkg::tok_flags_t tok_flags_in,
	input  logic [IDX_W-1:0]    tok_idx_in,
	input  logic [SIZE_WIDTH-1:0] tok_size_in,
	input  logic [SUM_W-1:0]    tok_sum_in,
	output fbwf_pkg::tok_flags_t tok_flags_q,
	output logic [IDX_W-1:0]    tok_idx_q,
	output logic [SIZE_WIDTH-1:0] tok_size_q,
	output logic [SUM_W-1:0]    tok_sum_q
);
	import fbwf_pkg::*;

	logic [SIZE_WIDTH-1:0] entry_q;
	logic                  in_use;
	logic                  adequate;
	logic                  better;
	logic                  take;

	// Block entry, written from the shared write bus
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
			entry_q <= wr_data;
		end
	end

	// Candidate compare against the token's current pick
	always_comb begin
		in_use   = CNT_W'(CELL_IDX) < count;
		adequate = in_use && (entry_q >= req_size);
		case (strategy)
			STRAT_BEST:  better = entry_q < tok_size_in;
			STRAT_WORST: better = entry_q > tok_size_in;
			default:     better = 1'b0;
		endcase
		take = adequate && (!tok_flags_in.found || better);
	end

	// Token hop to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_flags_q <= '0;
		end else begin
			tok_flags_q.valid <= tok_flags_in.valid;
			tok_flags_q.found <= tok_flags_in.found || adequate;
		end
	end

	always_ff @(posedge clk) begin
		tok_idx_q  <= take ? IDX_W'(CELL_IDX) : tok_idx_in;
		tok_size_q <= take ? entry_q : tok_size_in;
		tok_sum_q  <= in_use ? (tok_sum_in + SUM_W'(entry_q)) : tok_sum_in;
	end

endmodule

// File: rtl/core/fit_strategy_block_allocator.sv
// Top level of the fit-strategy block allocator: control, config port and cell chain.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  in       | in_valid / in_stall   | action, block_index, size, last_request
//  out      | out_valid / out_stall | granted, chosen_block, remaining, total_free,
//           |                       | batch_done
//  config   | APB psel/penable      | paddr, pwdata, prdata (strategy, block_count)
//
// In each beat the search token walks the cell chain one cell per cycle; the pick is then
// captured at the chain's end and committed from ST_FIN once the output register can take it.
// in_stall is high from acceptance until the result has moved to the output register;
// a new beat is taken while that result still waits on out_stall.
// Reset clears every block size, the strategy to first fit and block_count to 16.
// A full output register holds the finished search until out_stall drops.
`timescale 1ns / 1ps

module fit_strategy_block_allocator #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [3:0]  block_index,
	input  logic [15:0] size,
	input  logic        last_request,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [3:0]  chosen_block,
	output logic [15:0] remaining,
	output logic [19:0] total_free,
	output logic        batch_done
);
	import fbwf_pkg::*;

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W = SIZE_WIDTH + CNT_W;
	localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
	localparam int LW    = (CNT_W > 4) ? CNT_W : 4;
	localparam int TW    = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// config registers
	strat_t     strategy_q;
	logic [4:0] block_count_q;
	logic       cfg_wr;

	// current beat
	logic                  start_q;
	logic                  req_action_q;
	logic [3:0]            req_idx_q;
	logic [SIZE_WIDTH-1:0] req_size_q;
	logic                  req_last_q;
	logic                  load_ok_q;

	// captured search result
	logic                  fin_found_q;
	logic [IDX_W-1:0]      fin_idx_q;
	logic [SIZE_WIDTH-1:0] fin_size_q;
	logic [SUM_W-1:0]      fin_sum_q;

	// output register
	logic        out_valid_q;
	logic        granted_q;
	logic [3:0]  chosen_q;
	logic [15:0] remaining_q;
	logic [19:0] total_q;
	logic        batch_done_q;

	// combinational control
	logic [CW-1:0]         count_w;
	logic [CNT_W-1:0]      count;
	logic [SIZE_WIDTH-1:0] size_cut;
	logic                  in_accept;
	logic                  load_ok;
	logic                  fire;
	logic                  grant_req;
	logic [SIZE_WIDTH-1:0] rem_new;
	logic [SUM_W-1:0]      tot_raw;
	logic [TW-1:0]         tot_w;
	logic [TOTAL_W-1:0]    tot_sat;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [SIZE_WIDTH-1:0] wr_data;

	// token chain
	tok_flags_t            tf   [MAX_BLOCKS+1];
	logic [IDX_W-1:0]      ti   [MAX_BLOCKS+1];
	logic [SIZE_WIDTH-1:0] ts   [MAX_BLOCKS+1];
	logic [SUM_W-1:0]      tsum [MAX_BLOCKS+1];
	logic [MAX_BLOCKS:0]   tok_valid_vec;

	// APB port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q    <= STRAT_FIRST;
			block_count_q <= 5'd16;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_STRATEGY:    strategy_q    <= pwdata[1:0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[4:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_STRATEGY:    prdata = 32'(strategy_q);
			REG_BLOCK_COUNT: prdata = 32'(block_count_q);
			default:         prdata = '0;
		endcase
	end

	// Blocks in use: block_count saturated at MAX_BLOCKS
	always_comb begin
		count_w = (CW'(block_count_q) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
			: CW'(block_count_q);
		count = CNT_W'(count_w);
	end

	// Input side
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign size_cut  = SIZE_WIDTH'(size);
	assign load_ok   = LW'(block_index) < LW'(count);

	// Commit and result
	always_comb begin
		fire      = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
		grant_req = (req_action_q == ACT_REQUEST) && fin_found_q
			&& (strategy_q == STRAT_FIRST || strategy_q == STRAT_BEST
			|| strategy_q == STRAT_WORST);
		rem_new   = fin_size_q - req_size_q;
		tot_raw   = fin_sum_q - (grant_req ? SUM_W'(req_size_q) : '0);
		tot_w     = TW'(tot_raw);
		tot_sat   = (tot_w > TW'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(tot_w);
	end

	// Shared write bus to the cells: loads on accept, grants on commit
	always_comb begin
		wr_en   = (in_accept && (action == ACT_LOAD) && load_ok) || (fire && grant_req);
		wr_idx  = fire ? fin_idx_q : IDX_W'(block_index);
		wr_data = fire ? rem_new : size_cut;
	end

	// Sequencer, beat registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_accept;
			// output register: loaded on commit, emptied when its beat is taken
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tf[MAX_BLOCKS].valid) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_action_q <= action;
			req_idx_q    <= block_index;
			req_size_q   <= size_cut;
			req_last_q   <= last_request;
			load_ok_q    <= load_ok;
		end
		if (tf[MAX_BLOCKS].valid) begin
			fin_found_q <= tf[MAX_BLOCKS].found;
			fin_idx_q   <= ti[MAX_BLOCKS];
			fin_size_q  <= ts[MAX_BLOCKS];
			fin_sum_q   <= tsum[MAX_BLOCKS];
		end
		if (fire) begin
			batch_done_q <= req_last_q;
			total_q      <= tot_sat;
			if (req_action_q == ACT_LOAD) begin
				granted_q   <= load_ok_q;
				chosen_q    <= req_idx_q;
				remaining_q <= load_ok_q ? 16'(req_size_q) : '0;
			end else begin
				granted_q   <= grant_req;
				chosen_q    <= grant_req ? 4'(fin_idx_q) : '0;
				remaining_q <= grant_req ? 16'(rem_new) : '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign remaining    = remaining_q;
	assign total_free   = total_q;
	assign batch_done   = batch_done_q;

	// Token seed at the head of the chain
	assign tf[0]   = '{valid: start_q, found: 1'b0};
	assign ti[0]   = '0;
	assign ts[0]   = '0;
	assign tsum[0] = '0;

	// Cell chain
	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
		fbwf_cell #(
			.SIZE_WIDTH (SIZE_WIDTH),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.SUM_W      (SUM_W),
			.CELL_IDX   (k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.strategy     (strategy_q),
			.count        (count),
			.req_size     (req_size_q),
			.wr_en        (wr_en),
			.wr_idx       (wr_idx),
			.wr_data      (wr_data),
			.tok_flags_in (tf[k]),
			.tok_idx_in   (ti[k]),
			.tok_size_in  (ts[k]),
			.tok_sum_in   (tsum[k]),
			.tok_flags_q  (tf[k+1]),
			.tok_idx_q    (ti[k+1]),
			.tok_size_q   (ts[k+1]),
			.tok_sum_q    (tsum[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_BLOCKS; k++) begin : g_vvec
		assign tok_valid_vec[k] = tf[k].valid;
	end

	// Checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid_vec))
		else $error("more than one search token in the chain");

	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tf[MAX_BLOCKS].valid |-> state_q == ST_SCAN)
		else $error("search token left the chain outside a scan");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("output beat raised without a finished search");

	a_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_idx) < count))
		else $error("write to a block outside the blocks in use");

endmodule
